### rtl/zsed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsed_pkg: shared types and constants of the stored-entry deframer
// Result record layout, kind and error codes, header constants and queue size.
// ----------------------------------------------------------------------------
package zsed_pkg;

    localparam int          NAME_CAP      = 96;
    localparam logic [31:0] LOCAL_SIG     = 32'h04034b50;
    localparam logic [4:0]  HDR_LAST_POS  = 5'd29;
    localparam logic [7:0]  SLASH         = 8'h2f;
    localparam int          QUEUE_DEPTH   = 4;

    localparam logic [2:0] KIND_NAME     = 3'd0;
    localparam logic [2:0] KIND_START    = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd2;
    localparam logic [2:0] KIND_DIR_SKIP = 3'd3;
    localparam logic [2:0] KIND_FINISHED = 3'd4;
    localparam logic [2:0] KIND_ERROR    = 3'd5;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NAME_LEN  = 2'd1;
    localparam logic [1:0] ERR_METHOD    = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED = 2'd3;

    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_ONE  = 2'd1;
    localparam logic [1:0] WR_TWO  = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte_res;
        logic [6:0]  name_index;
        logic [6:0]  base_offset;
        logic [31:0] payload_size;
        logic        last_payload;
        logic [1:0]  error_code;
    } t_result;

    // Results produced by the parser for one accepted beat.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_front_out;

    function automatic t_result res_finish();
        t_result r;
        r      = '0;
        r.kind = KIND_FINISHED;
        return r;
    endfunction

    function automatic t_result res_fail(input logic [1:0] code);
        t_result r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

endpackage

### rtl/zsed_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsed_parser: header parser and entry sequencer
// Consumes one archive beat per cycle while i_accept is high and emits zero, one or two results.
// ----------------------------------------------------------------------------
module zsed_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_stream_end,
    output zsed_pkg::t_front_out  o_wr
);
    import zsed_pkg::*;

    typedef enum logic [6:0] {
        PH_HEADER  = 7'b0000001,
        PH_NAME    = 7'b0000010,
        PH_EXTRA   = 7'b0000100,
        PH_PAYLOAD = 7'b0001000,
        PH_SKIP    = 7'b0010000,
        PH_DONE    = 7'b0100000,
        PH_ERROR   = 7'b1000000
    } t_phase;

    typedef struct packed {
        t_phase     ph;
        t_result    res;
        logic [1:0] err;
    } t_settle;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_hp, n_hp;
    logic [15:0] r_method, n_method;
    logic [31:0] r_size, n_size;
    logic [15:0] r_name_len, n_name_len;
    logic [15:0] r_extra_len, n_extra_len;
    logic [31:0] r_remain, n_remain;
    logic [6:0]  r_slash_ofs, n_slash_ofs;
    logic        r_was_slash, n_was_slash;
    logic [1:0]  r_err, n_err;

    // Decide directory skip, method error or entry start once name/extra are done.
    function automatic t_settle settle(input logic s, input logic [15:0] m,
                                       input logic [31:0] e, input logic [6:0] base);
        t_settle st;
        st     = '0;
        st.ph  = PH_HEADER;
        st.err = ERR_NONE;
        if (s) begin
            st.res.kind = KIND_DIR_SKIP;
            st.ph       = (e != 32'd0) ? PH_SKIP : PH_HEADER;
        end else if (m != 16'd0) begin
            st.res = res_fail(ERR_METHOD);
            st.ph  = PH_ERROR;
            st.err = ERR_METHOD;
        end else begin
            st.res.kind         = KIND_START;
            st.res.base_offset  = base;
            st.res.payload_size = e;
            st.ph               = (e != 32'd0) ? PH_PAYLOAD : PH_HEADER;
        end
        return st;
    endfunction

    t_settle     st;
    logic [31:0] remain_dec;
    logic [31:0] idx_next;
    logic [7:0]  sig_byte;

    always_comb begin
        n_phase     = r_phase;
        n_hp        = r_hp;
        n_method    = r_method;
        n_size      = r_size;
        n_name_len  = r_name_len;
        n_extra_len = r_extra_len;
        n_remain    = r_remain;
        n_slash_ofs = r_slash_ofs;
        n_was_slash = r_was_slash;
        n_err       = r_err;
        o_wr        = '0;
        o_wr.cnt    = WR_NONE;
        st          = '0;
        remain_dec  = r_remain - 32'd1;
        idx_next    = r_remain + 32'd1;
        sig_byte    = LOCAL_SIG[{r_hp[1:0], 3'b000} +: 8];

        if (i_accept) begin
            case (r_phase)
                PH_DONE: begin
                    o_wr.cnt  = WR_ONE;
                    o_wr.res0 = res_finish();
                end
                PH_ERROR: begin
                    o_wr.cnt  = WR_ONE;
                    o_wr.res0 = res_fail(r_err);
                end
                default: begin
                    if (i_stream_end) begin
                        case (r_phase)
                            PH_NAME, PH_PAYLOAD: begin
                                o_wr.cnt  = WR_ONE;
                                o_wr.res0 = res_fail(ERR_TRUNCATED);
                                n_phase   = PH_ERROR;
                                n_err     = ERR_TRUNCATED;
                            end
                            PH_EXTRA: begin
                                if (r_was_slash) begin
                                    o_wr.cnt  = WR_ONE;
                                    o_wr.res0 = res_finish();
                                    n_phase   = PH_DONE;
                                    n_err     = ERR_NONE;
                                end else begin
                                    st        = settle(r_was_slash, r_method, r_size,
                                                       r_slash_ofs);
                                    o_wr.res0 = st.res;
                                    if (st.ph == PH_ERROR) begin
                                        o_wr.cnt = WR_ONE;
                                        n_phase  = PH_ERROR;
                                        n_err    = ERR_METHOD;
                                    end else if (st.ph == PH_PAYLOAD) begin
                                        o_wr.cnt  = WR_TWO;
                                        o_wr.res1 = res_fail(ERR_TRUNCATED);
                                        n_phase   = PH_ERROR;
                                        n_err     = ERR_TRUNCATED;
                                    end else begin
                                        o_wr.cnt  = WR_TWO;
                                        o_wr.res1 = res_finish();
                                        n_phase   = PH_DONE;
                                        n_err     = ERR_NONE;
                                    end
                                end
                            end
                            default: begin
                                o_wr.cnt  = WR_ONE;
                                o_wr.res0 = res_finish();
                                n_phase   = PH_DONE;
                                n_err     = ERR_NONE;
                            end
                        endcase
                    end else begin
                        case (r_phase)
                            PH_HEADER: begin
                                if (r_hp == 5'd0) begin
                                    n_method    = '0;
                                    n_size      = '0;
                                    n_name_len  = '0;
                                    n_extra_len = '0;
                                    n_slash_ofs = '0;
                                    n_was_slash = 1'b0;
                                end
                                if (r_hp < 5'd4 && i_data_byte != sig_byte) begin
                                    o_wr.cnt  = WR_ONE;
                                    o_wr.res0 = res_finish();
                                    n_phase   = PH_DONE;
                                    n_err     = ERR_NONE;
                                end else begin
                                    case (r_hp)
                                        5'd8:    n_method[7:0]     = i_data_byte;
                                        5'd9:    n_method[15:8]    = i_data_byte;
                                        5'd18:   n_size[7:0]       = i_data_byte;
                                        5'd19:   n_size[15:8]      = i_data_byte;
                                        5'd20:   n_size[23:16]     = i_data_byte;
                                        5'd21:   n_size[31:24]     = i_data_byte;
                                        5'd26:   n_name_len[7:0]   = i_data_byte;
                                        5'd27:   n_name_len[15:8]  = i_data_byte;
                                        5'd28:   n_extra_len[7:0]  = i_data_byte;
                                        5'd29:   n_extra_len[15:8] = i_data_byte;
                                        default: ;
                                    endcase
                                    if (r_hp == HDR_LAST_POS) begin
                                        n_hp = 5'd0;
                                        if (r_name_len == 16'd0 ||
                                            r_name_len >= 16'(NAME_CAP)) begin
                                            o_wr.cnt  = WR_ONE;
                                            o_wr.res0 = res_fail(ERR_NAME_LEN);
                                            n_phase   = PH_ERROR;
                                            n_err     = ERR_NAME_LEN;
                                        end else begin
                                            n_phase  = PH_NAME;
                                            n_remain = '0;
                                        end
                                    end else begin
                                        n_hp = r_hp + 5'd1;
                                    end
                                end
                            end
                            PH_NAME: begin
                                o_wr.cnt                = WR_ONE;
                                o_wr.res0.kind          = KIND_NAME;
                                o_wr.res0.data_byte_res = i_data_byte;
                                o_wr.res0.name_index    = r_remain[6:0];
                                n_was_slash             = (i_data_byte == SLASH);
                                if (i_data_byte == SLASH) begin
                                    n_slash_ofs = idx_next[6:0];
                                end
                                if (idx_next >= {16'd0, r_name_len}) begin
                                    if (r_extra_len != 16'd0) begin
                                        n_phase  = PH_EXTRA;
                                        n_remain = {16'd0, r_extra_len};
                                    end else begin
                                        st        = settle(n_was_slash, r_method, r_size,
                                                           n_slash_ofs);
                                        o_wr.cnt  = WR_TWO;
                                        o_wr.res1 = st.res;
                                        n_phase   = st.ph;
                                        n_err     = st.err;
                                        n_hp      = 5'd0;
                                        n_remain  = r_size;
                                    end
                                end else begin
                                    n_remain = idx_next;
                                end
                            end
                            PH_EXTRA: begin
                                n_remain = remain_dec;
                                if (remain_dec == 32'd0) begin
                                    st        = settle(r_was_slash, r_method, r_size,
                                                       r_slash_ofs);
                                    o_wr.cnt  = WR_ONE;
                                    o_wr.res0 = st.res;
                                    n_phase   = st.ph;
                                    n_err     = st.err;
                                    n_hp      = 5'd0;
                                    n_remain  = r_size;
                                end
                            end
                            PH_PAYLOAD: begin
                                o_wr.cnt                = WR_ONE;
                                o_wr.res0.kind          = KIND_PAYLOAD;
                                o_wr.res0.data_byte_res = i_data_byte;
                                o_wr.res0.last_payload  = (r_remain == 32'd1);
                                n_remain                = remain_dec;
                                if (remain_dec == 32'd0) begin
                                    n_phase = PH_HEADER;
                                    n_hp    = 5'd0;
                                end
                            end
                            PH_SKIP: begin
                                n_remain = remain_dec;
                                if (remain_dec == 32'd0) begin
                                    n_phase = PH_HEADER;
                                    n_hp    = 5'd0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hp        <= '0;
            r_method    <= '0;
            r_size      <= '0;
            r_name_len  <= '0;
            r_extra_len <= '0;
            r_remain    <= '0;
            r_slash_ofs <= '0;
            r_was_slash <= 1'b0;
            r_err       <= ERR_NONE;
        end else begin
            r_phase     <= n_phase;
            r_hp        <= n_hp;
            r_method    <= n_method;
            r_size      <= n_size;
            r_name_len  <= n_name_len;
            r_extra_len <= n_extra_len;
            r_remain    <= n_remain;
            r_slash_ofs <= n_slash_ofs;
            r_was_slash <= n_was_slash;
            r_err       <= n_err;
        end
    end

endmodule

### rtl/zsed_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsed_result_queue: result queue between parser and consumer
// Takes up to two results per cycle, hands out the oldest one per pop.
// ----------------------------------------------------------------------------
module zsed_result_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  zsed_pkg::t_front_out  i_wr,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output zsed_pkg::t_result     o_head
);
    import zsed_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_result       r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] wp_second;
    logic          pop_ok;

    assign o_empty   = (r_count == '0);
    // Hold off the parser unless two free slots remain.
    assign o_full    = (r_count > CW'(QUEUE_DEPTH - 2));
    assign o_head    = r_mem[r_rp];
    assign pop_ok    = i_pop && !o_empty;
    assign wp_second = r_wp + PW'(1);

    always_comb begin
        n_wp    = r_wp + PW'(i_wr.cnt);
        n_rp    = r_rp + PW'(pop_ok);
        n_count = r_count + CW'(i_wr.cnt) - CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.cnt != WR_NONE) begin
            r_mem[r_wp] <= i_wr.res0;
        end
        if (i_wr.cnt == WR_TWO) begin
            r_mem[wp_second] <= i_wr.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

### rtl/zip_stored_entry_deframer_core.sv
`timescale 1ns / 1ps
// Each result is registered in the result queue and read combinationally from its head.
// Throughput: one beat per cycle while full is low; the parser state updates every cycle.
// The four-entry result queue stalls input (full) when fewer than two slots are free.
// Reset: synchronous, active low; parser returns to header phase, queue empties.
// No clearing pass: the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
// zip_stored_entry_deframer_core: ZIP local-header deframer for stored entries
// Parses 30-byte local headers, passes name bytes, reports stored payloads.
// ----------------------------------------------------------------------------
module zip_stored_entry_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // archive side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_end,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data_byte_res,
    output logic [6:0]  o_name_index,
    output logic [6:0]  o_base_offset,
    output logic [31:0] o_payload_size,
    output logic        o_last_payload,
    output logic [1:0]  o_error_code
);
    import zsed_pkg::*;

    t_front_out wr;
    t_result    head;
    logic       accept;

    // Take a beat only when the queue can absorb the worst case of two results.
    assign accept = push && !full;

    // Front: classify each beat against the header/name/extra/payload phase
    // and emit name bytes, entry start, directory skip, payload bytes or a sticky end result.
    zsed_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_stream_end (i_stream_end),
        .o_wr         (wr)
    );

    // Back: buffer results so the consumer may stall without losing beats.
    zsed_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // Drive the result ports from the queue head.
    assign o_kind          = head.kind;
    assign o_data_byte_res = head.data_byte_res;
    assign o_name_index    = head.name_index;
    assign o_base_offset   = head.base_offset;
    assign o_payload_size  = head.payload_size;
    assign o_last_payload  = head.last_payload;
    assign o_error_code    = head.error_code;

endmodule

### tb/zip_stored_entry_deframer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zip_stored_entry_deframer_core_tb: self-checking bench for the ZIP deframer
// Streams one long archive of stored files and directories through the queue
// handshake, predicts every result beat and checks it field by field.
// ----------------------------------------------------------------------------
module zip_stored_entry_deframer_core_tb;
    import zsed_pkg::*;

    typedef enum logic [2:0] {
        HDR_COLLECT,
        NAME_PASS,
        EXTRA_DROP,
        DATA_PASS,
        DATA_DROP,
        ARCHIVE_DONE,
        ARCHIVE_FAIL
    } t_parse_phase;

    class deframe_scoreboard;
        t_parse_phase phase;
        logic [4:0]   hdr_pos;
        logic [15:0]  method;
        logic [31:0]  size;
        logic [15:0]  name_len;
        logic [15:0]  extra_len;
        logic [31:0]  count;
        logic [6:0]   base_off;
        logic         ends_in_slash;
        logic [1:0]   held_err;
        t_result      expected_q[$];
        int           beats_in;
        int           results_seen;
        int           files_started;
        int           dirs_skipped;
        int           mismatches;

        function new();
            phase         = HDR_COLLECT;
            hdr_pos       = '0;
            method        = '0;
            size          = '0;
            name_len      = '0;
            extra_len     = '0;
            count         = '0;
            base_off      = '0;
            ends_in_slash = 1'b0;
            held_err      = ERR_NONE;
            beats_in      = 0;
            results_seen  = 0;
            files_started = 0;
            dirs_skipped  = 0;
            mismatches    = 0;
        endfunction

        function void emit(logic [2:0] k, logic [7:0] b, logic [6:0] idx, logic [6:0] base,
                           logic [31:0] sz, logic last, logic [1:0] err);
            t_result r;
            r.kind          = k;
            r.data_byte_res = b;
            r.name_index    = idx;
            r.base_offset   = base;
            r.payload_size  = sz;
            r.last_payload  = last;
            r.error_code    = err;
            expected_q.push_back(r);
        endfunction

        function void finish_archive();
            phase    = ARCHIVE_DONE;
            held_err = ERR_NONE;
            emit(KIND_FINISHED, '0, '0, '0, '0, 1'b0, ERR_NONE);
        endfunction

        function void fail_archive(logic [1:0] code);
            phase    = ARCHIVE_FAIL;
            held_err = code;
            emit(KIND_ERROR, '0, '0, '0, '0, 1'b0, code);
        endfunction

        // Decide the entry once its name and extra field are consumed.
        function void close_entry_header();
            hdr_pos = '0;
            if (ends_in_slash) begin
                dirs_skipped++;
                emit(KIND_DIR_SKIP, '0, '0, '0, '0, 1'b0, ERR_NONE);
                if (size != 0) begin
                    phase = DATA_DROP;
                    count = size;
                end else begin
                    phase = HDR_COLLECT;
                end
            end else if (method != 0) begin
                fail_archive(ERR_METHOD);
            end else begin
                files_started++;
                emit(KIND_START, '0, '0, base_off, size, 1'b0, ERR_NONE);
                if (size != 0) begin
                    phase = DATA_PASS;
                    count = size;
                end else begin
                    phase = HDR_COLLECT;
                end
            end
        endfunction

        function void note_input(logic [7:0] b, logic stream_end);
            logic [6:0] idx;
            beats_in++;
            if (phase == ARCHIVE_DONE) begin
                emit(KIND_FINISHED, '0, '0, '0, '0, 1'b0, ERR_NONE);
                return;
            end
            if (phase == ARCHIVE_FAIL) begin
                emit(KIND_ERROR, '0, '0, '0, '0, 1'b0, held_err);
                return;
            end
            if (stream_end) begin
                case (phase)
                    NAME_PASS, DATA_PASS: fail_archive(ERR_TRUNCATED);
                    EXTRA_DROP: begin
                        if (ends_in_slash) begin
                            finish_archive();
                        end else begin
                            close_entry_header();
                            if (phase == DATA_PASS) fail_archive(ERR_TRUNCATED);
                            else if (phase == HDR_COLLECT) finish_archive();
                        end
                    end
                    default: finish_archive();
                endcase
                return;
            end
            case (phase)
                HDR_COLLECT: begin
                    if (hdr_pos == 0) begin
                        method        = '0;
                        size          = '0;
                        name_len      = '0;
                        extra_len     = '0;
                        base_off      = '0;
                        ends_in_slash = 1'b0;
                    end
                    if (hdr_pos < 4 && b != LOCAL_SIG[8*hdr_pos +: 8]) begin
                        finish_archive();
                        return;
                    end
                    case (hdr_pos)
                        5'd8:  method[7:0]     = b;
                        5'd9:  method[15:8]    = b;
                        5'd18: size[7:0]       = b;
                        5'd19: size[15:8]      = b;
                        5'd20: size[23:16]     = b;
                        5'd21: size[31:24]     = b;
                        5'd26: name_len[7:0]   = b;
                        5'd27: name_len[15:8]  = b;
                        5'd28: extra_len[7:0]  = b;
                        5'd29: extra_len[15:8] = b;
                        default: ;
                    endcase
                    if (hdr_pos == HDR_LAST_POS) begin
                        hdr_pos = '0;
                        if (name_len == 0 || name_len >= NAME_CAP) begin
                            fail_archive(ERR_NAME_LEN);
                        end else begin
                            phase = NAME_PASS;
                            count = '0;
                        end
                    end else begin
                        hdr_pos = hdr_pos + 5'd1;
                    end
                end
                NAME_PASS: begin
                    idx = count[6:0];
                    emit(KIND_NAME, b, idx, '0, '0, 1'b0, ERR_NONE);
                    ends_in_slash = (b == SLASH);
                    if (b == SLASH) base_off = idx + 7'd1;
                    if (count + 1 >= name_len) begin
                        if (extra_len != 0) begin
                            phase = EXTRA_DROP;
                            count = extra_len;
                        end else begin
                            close_entry_header();
                        end
                    end else begin
                        count = count + 1;
                    end
                end
                EXTRA_DROP: begin
                    count = count - 1;
                    if (count == 0) close_entry_header();
                end
                DATA_PASS: begin
                    emit(KIND_PAYLOAD, b, '0, '0, '0, count == 1, ERR_NONE);
                    count = count - 1;
                    if (count == 0) begin
                        phase   = HDR_COLLECT;
                        hdr_pos = '0;
                    end
                end
                DATA_DROP: begin
                    count = count - 1;
                    if (count == 0) begin
                        phase   = HDR_COLLECT;
                        hdr_pos = '0;
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result beat kind %0d with nothing expected",
                                          got.kind));
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("result %0d kind %0d, want %0d",
                                          results_seen, got.kind, want.kind));
            if (got.data_byte_res !== want.data_byte_res)
                report_mismatch($sformatf("result %0d data byte %h, want %h",
                                          results_seen, got.data_byte_res,
                                          want.data_byte_res));
            if (got.name_index !== want.name_index)
                report_mismatch($sformatf("result %0d name index %0d, want %0d",
                                          results_seen, got.name_index, want.name_index));
            if (got.base_offset !== want.base_offset)
                report_mismatch($sformatf("result %0d base offset %0d, want %0d",
                                          results_seen, got.base_offset, want.base_offset));
            if (got.payload_size !== want.payload_size)
                report_mismatch($sformatf("result %0d payload size %h, want %h",
                                          results_seen, got.payload_size,
                                          want.payload_size));
            if (got.last_payload !== want.last_payload)
                report_mismatch($sformatf("result %0d last flag %b, want %b",
                                          results_seen, got.last_payload,
                                          want.last_payload));
            if (got.error_code !== want.error_code)
                report_mismatch($sformatf("result %0d error code %0d, want %0d",
                                          results_seen, got.error_code, want.error_code));
            results_seen++;
        endtask
    endclass

    // How the single archive of the run is terminated.
    typedef enum int {
        END_CLEAN,
        END_BAD_SIG,
        END_IN_HEADER,
        END_NAME_LEN,
        END_METHOD,
        END_IN_NAME,
        END_IN_EXTRA,
        END_IN_SKIP,
        END_IN_PAYLOAD
    } t_archive_end;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_BEATS = 480;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte  = '0;
    logic        i_stream_end = 1'b0;
    logic        empty;
    logic        pop          = 1'b0;
    logic [2:0]  o_kind;
    logic [7:0]  o_data_byte_res;
    logic [6:0]  o_name_index;
    logic [6:0]  o_base_offset;
    logic [31:0] o_payload_size;
    logic        o_last_payload;
    logic [1:0]  o_error_code;

    deframe_scoreboard sb;
    int                send_idle_pct = 6;
    int                recv_idle_pct = 69;
    int                cycles        = 0;
    logic [7:0]        hdr_buf [0:29];
    t_archive_end      end_mode;

    zip_stored_entry_deframer_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_data_byte     (i_data_byte),
        .i_stream_end    (i_stream_end),
        .empty           (empty),
        .pop             (pop),
        .o_kind          (o_kind),
        .o_data_byte_res (o_data_byte_res),
        .o_name_index    (o_name_index),
        .o_base_offset   (o_base_offset),
        .o_payload_size  (o_payload_size),
        .o_last_payload  (o_last_payload),
        .o_error_code    (o_error_code)
    );

    // 10 ns clock: rising edges at 5, 15, 25 ...
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop: no correct run gets near this many cycles.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("zip_stored_entry_deframer_core test failed");
            $finish;
        end
    end

    // Receiver: decide pop once per falling edge, stalling at the current rate.
    always @(negedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result monitor: a beat moves at a rising edge with pop high and empty low.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && pop && !empty) begin
            got.kind          = o_kind;
            got.data_byte_res = o_data_byte_res;
            got.name_index    = o_name_index;
            got.base_offset   = o_base_offset;
            got.payload_size  = o_payload_size;
            got.last_payload  = o_last_payload;
            got.error_code    = o_error_code;
            sb.check_result(got);
        end
    end

    // Bias toward the byte values that matter: zero, all ones and the slash.
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return SLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] name_byte();
        if ($urandom_range(0, 4) == 0) return SLASH;
        return rand_byte();
    endfunction

    // Any value except the slash, so a file name never looks like a directory.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 254));
        if (b >= SLASH) b = b + 8'd1;
        return b;
    endfunction

    // Sizes for truncated entries: nonzero, often the all-ones extreme.
    function automatic logic [31:0] wide_size();
        logic [31:0] s;
        s = $urandom();
        if ($urandom_range(0, 2) == 0) s = '1;
        if (s == 0) s = 32'd1;
        return s;
    endfunction

    // Send one archive beat. Enter and leave on a falling edge; while idling,
    // drive junk on the payload ports so that ignoring it is checked too.
    task automatic send_beat(input logic [7:0] b, input logic e);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push         <= 1'b0;
            i_data_byte  <= 8'($urandom_range(0, 255));
            i_stream_end <= 1'($urandom_range(0, 1));
            @(negedge i_clk);
        end
        push         <= 1'b1;
        i_data_byte  <= b;
        i_stream_end <= e;
        @(posedge i_clk);
        // Hold the beat until the block has room.
        while (full) @(posedge i_clk);
        sb.note_input(b, e);
        @(negedge i_clk);
    endtask

    // Build a local header: valid signature, chosen fields, random filler.
    task automatic fill_header(input logic [15:0] meth, input logic [31:0] sz,
                               input logic [15:0] nlen, input logic [15:0] xlen);
        int k;
        for (k = 0; k < 30; k++) hdr_buf[k] = rand_byte();
        for (k = 0; k < 4; k++) hdr_buf[k] = LOCAL_SIG[8*k +: 8];
        hdr_buf[8]  = meth[7:0];
        hdr_buf[9]  = meth[15:8];
        hdr_buf[18] = sz[7:0];
        hdr_buf[19] = sz[15:8];
        hdr_buf[20] = sz[23:16];
        hdr_buf[21] = sz[31:24];
        hdr_buf[26] = nlen[7:0];
        hdr_buf[27] = nlen[15:8];
        hdr_buf[28] = xlen[7:0];
        hdr_buf[29] = xlen[15:8];
    endtask

    // Send one entry: header, then name, extra field and data. Stop after
    // body_cap bytes past the header; a negative cap sends the whole entry.
    task automatic send_entry(input bit is_dir, input logic [15:0] meth,
                              input logic [31:0] sz, input logic [15:0] nlen,
                              input logic [15:0] xlen, input longint body_cap);
        int         hk;
        longint     k;
        longint     sent;
        logic [7:0] b;
        fill_header(meth, sz, nlen, xlen);
        for (hk = 0; hk < 30; hk++) send_beat(hdr_buf[hk], 1'b0);
        sent = 0;
        if (nlen == 0 || nlen >= NAME_CAP) return;
        for (k = 0; k < nlen; k++) begin
            if (sent == body_cap) return;
            b = name_byte();
            if (k == nlen - 1) b = is_dir ? SLASH : plain_byte();
            send_beat(b, 1'b0);
            sent++;
        end
        for (k = 0; k < xlen; k++) begin
            if (sent == body_cap) return;
            send_beat(rand_byte(), 1'b0);
            sent++;
        end
        // A compressed file stops the archive here; nothing to stream.
        if (!is_dir && meth != 0) return;
        for (k = 0; k < sz; k++) begin
            if (sent == body_cap) return;
            send_beat(rand_byte(), 1'b0);
            sent++;
        end
    endtask

    // Terminate the archive in one of its ways, picked by the seed.
    task automatic end_archive();
        int          p;
        bit          is_dir;
        logic [15:0] meth;
        logic [15:0] nlen;
        logic [15:0] xlen;
        logic [31:0] sz;
        longint      part;
        end_mode = t_archive_end'($urandom_range(0, END_IN_PAYLOAD));
        nlen     = 16'($urandom_range(1, 8));
        case (end_mode)
            END_CLEAN: send_beat(rand_byte(), 1'b1);
            END_BAD_SIG: begin
                p = $urandom_range(0, 3);
                fill_header('0, '0, nlen, '0);
                for (int k = 0; k < p; k++) send_beat(hdr_buf[k], 1'b0);
                send_beat(hdr_buf[p] ^ 8'($urandom_range(1, 255)), 1'b0);
            end
            END_IN_HEADER: begin
                p = $urandom_range(1, 29);
                fill_header(16'($urandom()), $urandom(), nlen, '0);
                for (int k = 0; k < p; k++) send_beat(hdr_buf[k], 1'b0);
                send_beat(rand_byte(), 1'b1);
            end
            END_NAME_LEN: begin
                case ($urandom_range(0, 3))
                    0:       nlen = '0;
                    1:       nlen = 16'(NAME_CAP);
                    2:       nlen = '1;
                    default: nlen = 16'($urandom_range(NAME_CAP, 65535));
                endcase
                send_entry($urandom_range(0, 1), '0, '0, nlen, '0, 0);
            end
            END_METHOD: begin
                xlen = 16'($urandom_range(0, 3));
                send_entry(1'b0, 16'($urandom_range(1, 65535)), 32'($urandom_range(0, 9)),
                           nlen, xlen, nlen + xlen);
            end
            END_IN_NAME: begin
                nlen = 16'($urandom_range(2, NAME_CAP - 1));
                send_entry(1'b0, '0, 32'd4, nlen, '0, $urandom_range(0, nlen - 1));
                send_beat(rand_byte(), 1'b1);
            end
            END_IN_EXTRA: begin
                is_dir = $urandom_range(0, 1);
                meth   = $urandom_range(0, 1) ? 16'($urandom_range(1, 65535)) : '0;
                sz     = $urandom_range(0, 1) ? wide_size() : '0;
                xlen   = ($urandom_range(0, 3) == 0) ? '1 : 16'($urandom_range(1, 8));
                part   = $urandom_range(0, (xlen > 10) ? 10 : xlen - 1);
                send_entry(is_dir, meth, sz, nlen, xlen, nlen + part);
                send_beat(rand_byte(), 1'b1);
            end
            END_IN_SKIP: begin
                sz   = wide_size();
                xlen = 16'($urandom_range(0, 3));
                part = $urandom_range(0, (sz > 10) ? 10 : sz - 1);
                send_entry(1'b1, 16'($urandom()), sz, nlen, xlen, nlen + xlen + part);
                send_beat(rand_byte(), 1'b1);
            end
            default: begin
                sz   = $urandom_range(0, 1) ? wide_size() : 32'($urandom_range(1, 12));
                xlen = 16'($urandom_range(0, 3));
                part = $urandom_range(0, (sz > 20) ? 20 : sz - 1);
                send_entry(1'b0, '0, sz, nlen, xlen, nlen + xlen + part);
                send_beat(rand_byte(), 1'b1);
            end
        endcase
    endtask

    initial begin
        int          first_random;
        int          done_random;
        bit          is_dir;
        logic [15:0] nlen;
        logic [15:0] xlen;
        logic [31:0] sz;

        sb = new();

        // Hold reset, then release it on a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed entries: smallest file, extra field, directories with and
        // without data (both with a method that must be ignored), longest name.
        send_entry(1'b0, '0, '0, 16'd1, '0, -1);
        send_entry(1'b0, '0, 32'd4, 16'd6, 16'd3, -1);
        send_entry(1'b1, '1, '0, 16'd2, '0, -1);
        send_entry(1'b1, 16'd8, 32'd3, 16'd4, 16'd1, -1);
        send_entry(1'b0, '0, 32'd1, 16'(NAME_CAP - 1), '0, -1);

        // Random well-formed entries; the idle mix moves through three stages.
        first_random = sb.beats_in;
        done_random  = 0;
        while (done_random < RANDOM_BEATS) begin
            if (done_random < RANDOM_BEATS / 3) begin
                send_idle_pct = 6;
                recv_idle_pct = 69;
            end else if (done_random < 2 * RANDOM_BEATS / 3) begin
                send_idle_pct = 69;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            is_dir = ($urandom_range(0, 4) == 0);
            nlen   = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(9, NAME_CAP - 1))
                                                 : 16'($urandom_range(1, 8));
            xlen   = $urandom_range(0, 1) ? 16'($urandom_range(1, 6)) : '0;
            sz     = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(17, 40))
                                                 : 32'($urandom_range(0, 16));
            send_entry(is_dir, is_dir ? 16'($urandom()) : '0, sz, nlen, xlen, -1);
            done_random = sb.beats_in - first_random;
        end

        // Close the archive, then keep pushing: the end result must repeat.
        end_archive();
        repeat (16) send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        push <= 1'b0;

        // Drain, then keep watching for any stray result beat.
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d archive beats, %0d result beats checked", sb.beats_in,
                 sb.results_seen);
        $display("%0d stored files, %0d directories, archive closed by %s",
                 sb.files_started, sb.dirs_skipped, end_mode.name());
        if (sb.mismatches == 0) begin
            $display("zip_stored_entry_deframer_core test passed");
        end else begin
            $display("zip_stored_entry_deframer_core test failed");
        end
        $finish;
    end

endmodule
